### rtl/fla_pkg.sv
package fla_pkg;

   // Internal arithmetic width: holds a segment end plus header and alignment slack.
   localparam int CW = 24;

   // Field widths of the request and response beats.
   localparam int KIND_W  = 2;
   localparam int REQ_W   = 21;
   localparam int ALOG_W  = 4;
   localparam int ADDR_W  = 20;
   localparam int STAT_W  = 2;
   localparam int BYTES_W = 21;
   localparam int CAP_W   = 21;

   // Default sizing of the top level.
   localparam int DEF_FREE_SLOTS   = 32;
   localparam int DEF_LIVE_SLOTS   = 32;
   localparam int DEF_ADDR_BITS    = 20;
   localparam int DEF_HEADER_BYTES = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd3;

   // Register indexes on the configuration port.
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_POLICY   = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 21'h100000;

   typedef struct packed {
      logic [CW-1:0] base;
      logic [CW-1:0] size;
   } seg_type;

   typedef struct packed {
      logic [CW-1:0] addr;
      logic [CW-1:0] size;
      logic [CW-1:0] pad;
   } live_type;

   typedef struct packed {
      logic          fits;
      logic [CW-1:0] data;
      logic [CW-1:0] need;
      logic [CW-1:0] rest;
   } fit_res_type;

endpackage

### rtl/fla_fit_unit.sv
module fla_fit_unit #(
   parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
   input  fla_pkg::seg_type              seg,
   input  logic [fla_pkg::CW-1:0]        req_size,
   input  logic [fla_pkg::ALOG_W-1:0]    align_log2,
   output fla_pkg::fit_res_type          res
);
   import fla_pkg::*;

   logic [CW-1:0] mask;
   logic [CW-1:0] data;
   logic [CW-1:0] need;

   // Lowest aligned data address that leaves room for the header above the base.
   always_comb begin
      mask     = (CW'(1) << align_log2) - CW'(1);
      data     = (seg.base + CW'(HEADER_BYTES) + mask) & ~mask;
      need     = (data - seg.base) + req_size;
      res.fits = seg.size >= need;
      res.data = data;
      res.need = need;
      res.rest = seg.size - need;
   end

endmodule

### rtl/free_list_allocator.sv
// Channel    Ports                                    Direction  Handshake
// request    req_kind/request_bytes/align_log2/...    in         start high while busy low
// response   rsp_data_address/status/bytes_*          out        rsp_strobe for one cycle
// config     psel/penable/pwrite/paddr/pwdata/prdata  in/out     APB write, pready always high
//
// An allocate beat checks the live slots in turn for an empty entry, examines the free
// segments one at a time in the shared fit unit, and moves entries when a segment is
// removed; a free beat compares the live entries, scans the free segments and moves entries.
// After reset the block writes the initial segment before it accepts.
// The receiver cannot stall; the response strobe comes in the first cycle with busy low.
module free_list_allocator #(
   parameter int FREE_SLOTS   = fla_pkg::DEF_FREE_SLOTS,
   parameter int LIVE_SLOTS   = fla_pkg::DEF_LIVE_SLOTS,
   parameter int ADDR_BITS    = fla_pkg::DEF_ADDR_BITS,
   parameter int HEADER_BYTES = fla_pkg::DEF_HEADER_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fla_pkg::KIND_W-1:0]    req_kind,
   input  logic [fla_pkg::REQ_W-1:0]     req_request_bytes,
   input  logic [fla_pkg::ALOG_W-1:0]    req_align_log2,
   input  logic [fla_pkg::ADDR_W-1:0]    req_free_address,
   output logic                          rsp_strobe,
   output logic [fla_pkg::ADDR_W-1:0]    rsp_data_address,
   output logic [fla_pkg::STAT_W-1:0]    rsp_status,
   output logic [fla_pkg::BYTES_W-1:0]   rsp_bytes_used,
   output logic [fla_pkg::BYTES_W-1:0]   rsp_bytes_peak,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import fla_pkg::*;

   localparam int FIW = $clog2(FREE_SLOTS);
   localparam int FCW = $clog2(FREE_SLOTS + 1);
   localparam int LIW = $clog2(LIVE_SLOTS);
   localparam logic [63:0] LIM = 64'd1 << ADDR_BITS;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_LSCAN, S_FRD, S_FEV, S_ACOMMIT, S_SHRD, S_SHWR,
      S_KRD, S_KEV, S_PRD, S_PEV, S_FCOMMIT, S_SURD, S_SUWR, S_RESP
   } state_type;

   // Memories.
   seg_type  fmem [FREE_SLOTS];
   live_type lmem [LIVE_SLOTS];
   seg_type  f_rd_q;
   live_type l_rd_q;
   logic     f_we, f_re, l_we, l_re;
   logic [FIW-1:0] f_wa, f_ra;
   logic [LIW-1:0] l_ra;
   seg_type  f_wd;
   live_type l_wd;

   // Registers.
   state_type              state_ff, state_in;
   logic [FCW-1:0]         fcnt_ff, fcnt_in;
   logic [LIVE_SLOTS-1:0]  valid_ff, valid_in;
   logic [CW-1:0]          used_ff, used_in, peak_ff, peak_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   policy_ff, policy_in;
   logic [FCW-1:0]         i_ff, i_in, j_ff, j_in, p_ff, p_in;
   logic [LIW-1:0]         slot_ff, slot_in;
   logic [FIW-1:0]         found_ff, found_in;
   logic                   found_any_ff, found_any_in;
   logic [CW-1:0]          best_rest_ff, best_rest_in, best_data_ff, best_data_in;
   logic [CW-1:0]          best_need_ff, best_need_in;
   logic [CW-1:0]          req_size_ff, req_size_in;
   logic [ALOG_W-1:0]      alog_ff, alog_in;
   logic [CW-1:0]          faddr_ff, faddr_in;
   logic [CW-1:0]          blk_base_ff, blk_base_in, blk_size_ff, blk_size_in;
   seg_type                prev_ff, prev_in, cur_ff, cur_in;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [CW-1:0]          res_addr_ff, res_addr_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [BYTES_W-1:0]     rsp_used_ff, rsp_used_in, rsp_peak_ff, rsp_peak_in;

   logic [CW-1:0] cap_eff;
   logic [CW-1:0] blk_end;
   logic [CW-1:0] used_add;
   logic          mp, mn, cfg_wr;
   logic [FCW-1:0] pm1;
   fit_res_type   fit;

   // Shared fit evaluation on the segment just read.
   fla_fit_unit #(.HEADER_BYTES(HEADER_BYTES)) u_fit (
      .seg        (f_rd_q),
      .req_size   (req_size_ff),
      .align_log2 (alog_ff),
      .res        (fit)
   );

   always_ff @(posedge clock) begin
      if (f_we) begin
         fmem[f_wa] <= f_wd;
      end
      if (f_re) begin
         f_rd_q <= fmem[f_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         lmem[slot_ff] <= l_wd;
      end
      if (l_re) begin
         l_rd_q <= lmem[l_ra];
      end
   end

   // Configuration port.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_POLICY) ? {31'd0, policy_ff} : {11'd0, cap_ff};

   // Capacity clamped to the address space.
   assign cap_eff = (64'(cap_ff) > LIM) ? LIM[CW-1:0] : CW'(cap_ff);
   assign blk_end = blk_base_ff + blk_size_ff;
   assign mp = (p_ff != '0) && (prev_ff.base + prev_ff.size == blk_base_ff);
   assign mn = (p_ff < fcnt_ff) && (cur_ff.base == blk_end);
   assign pm1 = p_ff - FCW'(1);
   assign used_add = used_ff + best_need_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      fcnt_in       = fcnt_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      peak_in       = peak_ff;
      cap_in        = cap_ff;
      policy_in     = policy_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      slot_in       = slot_ff;
      found_in      = found_ff;
      found_any_in  = found_any_ff;
      best_rest_in  = best_rest_ff;
      best_data_in  = best_data_ff;
      best_need_in  = best_need_ff;
      req_size_in   = req_size_ff;
      alog_in       = alog_ff;
      faddr_in      = faddr_ff;
      blk_base_in   = blk_base_ff;
      blk_size_in   = blk_size_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_peak_in   = rsp_peak_ff;
      f_we = 1'b0;
      f_wa = '0;
      f_wd = '0;
      f_re = 1'b0;
      f_ra = i_ff[FIW-1:0];
      l_we = 1'b0;
      l_wd = '0;
      l_re = 1'b0;
      l_ra = slot_ff;

      if (cfg_wr) begin
         if (paddr[2] == REG_POLICY) begin
            policy_in = pwdata[0];
         end else begin
            cap_in = pwdata[CAP_W-1:0];
         end
      end

      unique case (state_ff)
         S_INIT: begin
            f_we     = 1'b1;
            f_wd     = '{base: '0, size: cap_eff};
            fcnt_in  = FCW'(cap_eff != '0);
            valid_in = '0;
            used_in  = '0;
            peak_in  = '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_size_in = (req_request_bytes == '0) ? CW'(1) : CW'(req_request_bytes);
               alog_in     = req_align_log2;
               faddr_in    = CW'(req_free_address);
               status_in   = STAT_OK;
               res_addr_in = '0;
               slot_in     = '0;
               found_any_in = 1'b0;
               unique case (req_kind)
                  KIND_ALLOC: state_in = S_LSCAN;
                  KIND_FREE:  state_in = S_KRD;
                  KIND_RESET: begin
                     f_we     = 1'b1;
                     f_wd     = '{base: '0, size: cap_eff};
                     fcnt_in  = FCW'(cap_eff != '0);
                     valid_in = '0;
                     used_in  = '0;
                     peak_in  = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         // Find the lowest empty live slot.
         S_LSCAN: begin
            if (!valid_ff[slot_ff]) begin
               i_in     = '0;
               state_in = S_FRD;
            end else if (slot_ff == LIW'(LIVE_SLOTS - 1)) begin
               status_in = STAT_FULL;
               state_in  = S_RESP;
            end else begin
               slot_in = slot_ff + LIW'(1);
            end
         end
         // Walk the free segments through the fit unit.
         S_FRD: begin
            if (i_ff == fcnt_ff) begin
               if (found_any_ff) begin
                  state_in = S_ACOMMIT;
               end else begin
                  status_in = STAT_NO_FIT;
                  state_in  = S_RESP;
               end
            end else begin
               f_re     = 1'b1;
               state_in = S_FEV;
            end
         end
         S_FEV: begin
            i_in     = i_ff + FCW'(1);
            state_in = S_FRD;
            if (fit.fits && (!found_any_ff || fit.rest < best_rest_ff)) begin
               found_any_in = 1'b1;
               found_in     = i_ff[FIW-1:0];
               best_rest_in = fit.rest;
               best_data_in = fit.data;
               best_need_in = fit.need;
               if (!policy_ff) begin
                  state_in = S_ACOMMIT;
               end
            end
         end
         // Record the block and cut it from the chosen segment.
         S_ACOMMIT: begin
            l_we        = 1'b1;
            l_wd        = '{addr: best_data_ff, size: best_need_ff,
                            pad: best_need_ff - req_size_ff};
            valid_in[slot_ff] = 1'b1;
            used_in     = used_add;
            peak_in     = (used_add > peak_ff) ? used_add : peak_ff;
            res_addr_in = best_data_ff;
            if (best_rest_ff != '0) begin
               f_we     = 1'b1;
               f_wa     = found_ff;
               f_wd     = '{base: best_data_ff + req_size_ff, size: best_rest_ff};
               state_in = S_RESP;
            end else begin
               j_in     = FCW'(found_ff);
               state_in = S_SHRD;
            end
         end
         // Close the gap left by a removed segment.
         S_SHRD: begin
            if (j_ff + FCW'(1) < fcnt_ff) begin
               f_re     = 1'b1;
               f_ra     = FIW'(j_ff + FCW'(1));
               state_in = S_SHWR;
            end else begin
               fcnt_in  = fcnt_ff - FCW'(1);
               state_in = S_RESP;
            end
         end
         S_SHWR: begin
            f_we     = 1'b1;
            f_wa     = j_ff[FIW-1:0];
            f_wd     = f_rd_q;
            j_in     = j_ff + FCW'(1);
            state_in = S_SHRD;
         end
         // Look up the live block by its data address.
         S_KRD: begin
            l_re     = 1'b1;
            state_in = S_KEV;
         end
         S_KEV: begin
            if (valid_ff[slot_ff] && l_rd_q.addr == faddr_ff) begin
               blk_base_in = faddr_ff - l_rd_q.pad;
               blk_size_in = l_rd_q.size;
               i_in        = '0;
               state_in    = S_PRD;
            end else if (slot_ff == LIW'(LIVE_SLOTS - 1)) begin
               status_in = STAT_UNKNOWN;
               state_in  = S_RESP;
            end else begin
               slot_in  = slot_ff + LIW'(1);
               state_in = S_KRD;
            end
         end
         // Find the first free segment above the block, keeping its predecessor.
         S_PRD: begin
            if (i_ff == fcnt_ff) begin
               p_in     = fcnt_ff;
               state_in = S_FCOMMIT;
            end else begin
               f_re     = 1'b1;
               state_in = S_PEV;
            end
         end
         S_PEV: begin
            if (f_rd_q.base > blk_base_ff) begin
               p_in     = i_ff;
               cur_in   = f_rd_q;
               state_in = S_FCOMMIT;
            end else begin
               prev_in  = f_rd_q;
               i_in     = i_ff + FCW'(1);
               state_in = S_PRD;
            end
         end
         // Merge with the neighbors or insert a new segment; report full if no slot is left.
         S_FCOMMIT: begin
            if (!mp && !mn && fcnt_ff >= FCW'(FREE_SLOTS)) begin
               status_in = STAT_FULL;
               state_in  = S_RESP;
            end else begin
               valid_in[slot_ff] = 1'b0;
               used_in = used_ff - blk_size_ff;
               if (mp && mn) begin
                  f_we     = 1'b1;
                  f_wa     = pm1[FIW-1:0];
                  f_wd     = '{base: prev_ff.base,
                               size: prev_ff.size + blk_size_ff + cur_ff.size};
                  j_in     = p_ff;
                  state_in = S_SHRD;
               end else if (mp) begin
                  f_we     = 1'b1;
                  f_wa     = pm1[FIW-1:0];
                  f_wd     = '{base: prev_ff.base, size: prev_ff.size + blk_size_ff};
                  state_in = S_RESP;
               end else if (mn) begin
                  f_we     = 1'b1;
                  f_wa     = p_ff[FIW-1:0];
                  f_wd     = '{base: blk_base_ff, size: cur_ff.size + blk_size_ff};
                  state_in = S_RESP;
               end else begin
                  j_in     = fcnt_ff;
                  state_in = S_SURD;
               end
            end
         end
         // Open a slot at the insertion point, moving the upper entries up one.
         S_SURD: begin
            if (j_ff > p_ff) begin
               f_re     = 1'b1;
               f_ra     = FIW'(j_ff - FCW'(1));
               state_in = S_SUWR;
            end else begin
               f_we     = 1'b1;
               f_wa     = p_ff[FIW-1:0];
               f_wd     = '{base: blk_base_ff, size: blk_size_ff};
               fcnt_in  = fcnt_ff + FCW'(1);
               state_in = S_RESP;
            end
         end
         S_SUWR: begin
            f_we     = 1'b1;
            f_wa     = j_ff[FIW-1:0];
            f_wd     = f_rd_q;
            j_in     = j_ff - FCW'(1);
            state_in = S_SURD;
         end
         // Present the response beat.
         S_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_addr_in   = (status_ff == STAT_OK) ? res_addr_ff[ADDR_W-1:0] : '0;
            rsp_status_in = status_ff;
            rsp_used_in   = used_ff[BYTES_W-1:0];
            rsp_peak_in   = peak_ff[BYTES_W-1:0];
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         fcnt_ff       <= '0;
         valid_ff      <= '0;
         used_ff       <= '0;
         peak_ff       <= '0;
         cap_ff        <= CAP_RESET;
         policy_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         found_any_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fcnt_ff       <= fcnt_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         peak_ff       <= peak_in;
         cap_ff        <= cap_in;
         policy_ff     <= policy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_any_ff  <= found_any_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      p_ff         <= p_in;
      slot_ff      <= slot_in;
      found_ff     <= found_in;
      best_rest_ff <= best_rest_in;
      best_data_ff <= best_data_in;
      best_need_ff <= best_need_in;
      req_size_ff  <= req_size_in;
      alog_ff      <= alog_in;
      faddr_ff     <= faddr_in;
      blk_base_ff  <= blk_base_in;
      blk_size_ff  <= blk_size_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      status_ff    <= status_in;
      res_addr_ff  <= res_addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_peak_ff  <= rsp_peak_in;
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bytes_used   = rsp_used_ff;
   assign rsp_bytes_peak   = rsp_peak_ff;

endmodule
